// ----- design/s2d_pkg.sv -----
// shared constants, types and state codes for the signed decimal text converter
`default_nettype none
package s2d_pkg;

  // width of the signed input value
  localparam int VALUE_BITS = 32;
  // decimal digits needed for the largest magnitude, 2**(VALUE_BITS-1)
  localparam int NUM_DIGITS = (VALUE_BITS * 301) / 1000 + 1;
  localparam int DIGIT_W    = 4;
  localparam int CNT_W      = $clog2(VALUE_BITS);
  localparam int POS_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam int         RADIX      = 10;
  // double dabble correction: digits at or above half the radix get this added
  localparam logic [DIGIT_W-1:0] BCD_LIMIT = DIGIT_W'(RADIX / 2);
  localparam logic [DIGIT_W-1:0] BCD_ADJ   = DIGIT_W'(16 - RADIX) >> 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_PREFIX,
    S_DIGITS
  } s2d_state_t;

  // control word broadcast to every digit cell
  typedef struct packed {
    logic clear;    // zero the digit
    logic convert;  // one double dabble step
    logic emit;     // take the lower neighbor's digit
  } s2d_cell_ctrl_t;

endpackage : s2d_pkg
`default_nettype wire

// ----- design/s2d_if.sv -----
// valid/ready channel interfaces for the converter input and output
`default_nettype none
interface s2d_in_if;
  import s2d_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;
  logic                         pad_two;
  modport source (output valid, output value, output pad_two, input ready);
  modport sink (input valid, input value, input pad_two, output ready);
endinterface : s2d_in_if

interface s2d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;
  modport source (output valid, output out_char, output last, input ready);
  modport sink (input valid, input out_char, input last, output ready);
endinterface : s2d_out_if
`default_nettype wire

// ----- design/s2d_digit_cell.sv -----
// one bcd digit cell of the double dabble chain
`default_nettype none
module s2d_digit_cell (
  input  wire                             clk,
  input  wire  s2d_pkg::s2d_cell_ctrl_t   ctrl,
  input  wire                             bin_in,
  input  wire  [s2d_pkg::DIGIT_W-1:0]     dig_in,
  output logic                            bin_out,
  output logic [s2d_pkg::DIGIT_W-1:0]     digit
);
  import s2d_pkg::*;

  logic [DIGIT_W-1:0] corrected;

  // add-3 correction ahead of the shift
  always_comb begin
    corrected = (digit >= BCD_LIMIT) ? digit + BCD_ADJ : digit;
    bin_out   = corrected[DIGIT_W-1];
  end

  // digit register: clear, shift in a binary bit, or take the neighbor digit
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.convert) begin
      digit <= {corrected[DIGIT_W-2:0], bin_in};
    end else if (ctrl.emit) begin
      digit <= dig_in;
    end
  end

endmodule : s2d_digit_cell
`default_nettype wire

// ----- design/signed_int_to_decimal_ascii_core.sv -----
// Signed integer to decimal ASCII converter, top level.
// Sequence: a load in idle, then double dabble conversion through the digit cell
// chain, then leading zeros are skipped and the characters are sent one by one.
// One item at a time: a new value is taken only once its last character is sent.
// The bit counter cnt, not the binary shift register, sets the conversion length.
// Reset (rst, synchronous, active high) returns to idle; the digit cells need none.
`default_nettype none
module signed_int_to_decimal_ascii_core (
  input  wire       clk,
  input  wire       rst,
  s2d_in_if.sink    din,
  s2d_out_if.source dout
);
  import s2d_pkg::*;

  s2d_state_t              state, state_next;
  logic [VALUE_BITS-1:0]   mag;
  logic [CNT_W-1:0]        cnt;
  logic [POS_W-1:0]        pos;
  logic                    started;
  logic                    neg;
  logic                    need_prefix;
  logic [VALUE_BITS-1:0]   load_mag;
  logic                    load_neg;
  logic                    in_xfer;
  logic                    out_xfer;
  logic                    top_zero;
  s2d_cell_ctrl_t          ctrl;
  logic [DIGIT_W-1:0]      digits [NUM_DIGITS];
  logic [NUM_DIGITS-1:0]   carry;

  assign in_xfer  = din.valid && din.ready;
  assign out_xfer = dout.valid && dout.ready;
  assign load_neg = din.value[VALUE_BITS-1];
  assign load_mag = load_neg ? (~din.value + VALUE_BITS'(1)) : din.value;
  assign top_zero = (digits[NUM_DIGITS-1] == '0);

  // chain of digit cells, least significant first
  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    s2d_digit_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .bin_in  ((i == 0) ? mag[VALUE_BITS-1] : carry[(i == 0) ? 0 : i-1]),
      .dig_in  ((i == 0) ? DIGIT_W'(0) : digits[(i == 0) ? 0 : i-1]),
      .bin_out (carry[i]),
      .digit   (digits[i])
    );
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mag         <= load_mag;
      neg         <= load_neg;
      need_prefix <= load_neg || (din.pad_two && (load_mag < VALUE_BITS'(RADIX)));
      cnt         <= '0;
    end else if (state == S_CONV) begin
      mag <= {mag[VALUE_BITS-2:0], 1'b0};
      cnt <= cnt + CNT_W'(1);
    end
    if (state == S_CONV) begin
      pos     <= POS_W'(NUM_DIGITS - 1);
      started <= 1'b0;
    end else if (ctrl.emit) begin
      // only a sent digit ends leading zero suppression
      pos     <= pos - POS_W'(1);
      started <= started || out_xfer;
    end
  end

  // next state, cell control and output
  always_comb begin
    state_next    = state;
    ctrl          = '0;
    din.ready     = 1'b0;
    dout.valid    = 1'b0;
    dout.out_char = CHAR_ZERO + {4'b0000, digits[NUM_DIGITS-1]};
    dout.last     = 1'b0;
    unique case (state)
      S_IDLE: begin
        din.ready = 1'b1;
        if (din.valid) begin
          ctrl.clear = 1'b1;
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        ctrl.convert = 1'b1;
        if (cnt == CNT_W'(VALUE_BITS - 1)) begin
          state_next = need_prefix ? S_PREFIX : S_DIGITS;
        end
      end
      S_PREFIX: begin
        dout.valid    = 1'b1;
        dout.out_char = neg ? CHAR_MINUS : CHAR_ZERO;
        if (dout.ready) begin
          state_next = S_DIGITS;
        end
      end
      S_DIGITS: begin
        if (!started && top_zero && (pos != '0)) begin
          // leading zero, drop it
          ctrl.emit = 1'b1;
        end else begin
          dout.valid = 1'b1;
          dout.last  = (pos == '0);
          if (dout.ready) begin
            ctrl.emit = 1'b1;
            if (pos == '0) begin
              state_next = S_IDLE;
            end
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule : signed_int_to_decimal_ascii_core
`default_nettype wire

// ----- design/s2d_checker.sv -----
// port level assertions for the converter, bound to the top level
`default_nettype none
module s2d_checker (
  input wire       clk,
  input wire       rst,
  input wire       in_valid,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire [7:0] out_char,
  input wire       last
);
  import s2d_pkg::*;

  // a stalled character holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(last))
    else $error("output changed while stalled");

  // no new item while a character is pending
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while output pending");

  // after an input transfer the block is busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after transfer");

  // only minus or decimal digits leave the block
  a_char_set: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_char == CHAR_MINUS) ||
                  ((out_char >= CHAR_ZERO) && (out_char <= CHAR_ZERO + 8'd9)))
    else $error("illegal character");

  // a minus sign never ends a number
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_char == CHAR_MINUS) |-> !last)
    else $error("minus flagged last");

endmodule : s2d_checker

bind signed_int_to_decimal_ascii_core s2d_checker u_s2d_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (din.valid),
  .in_ready  (din.ready),
  .out_valid (dout.valid),
  .out_ready (dout.ready),
  .out_char  (dout.out_char),
  .last      (dout.last)
);
`default_nettype wire
